/* src/gpr_pkg.sv */
`default_nettype none
package gpr_pkg;

  // line buffer depth, widest source row
  localparam int MAX_WIDTH    = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WIDTH_W      = COL_W + 1;

  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_W        = 12;
  localparam int HEIGHT_W     = ROW_W + 1;

  localparam int PIX_W        = 8;
  localparam int OUT_IDX_W    = 11;
  localparam int UPSUM_W      = 11;
  localparam int VSUM_W       = 12;
  localparam int HSUM_W       = 17;
  localparam int WIN          = 5;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_MODE   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

  // binomial taps and their edge-folded forms
  localparam int TAP_4      = 4;
  localparam int TAP_5      = 5;
  localparam int TAP_6      = 6;
  localparam int TAP_11     = 11;
  localparam int ROUND_BIAS = 128;
  localparam int NORM_SHIFT = 8;

endpackage
`default_nettype wire

/* src/gpr_ifs.sv */
`default_nettype none
// source pixel channel
interface gpr_pix_if;
  import gpr_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// reduced pixel channel
interface gpr_res_if;
  import gpr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     pixel_out;
  logic [OUT_IDX_W-1:0] out_col;
  logic [OUT_IDX_W-1:0] out_row;
  logic                 run_last;
  logic                 frame_last;

  modport source (output valid, output pixel_out, output out_col, output out_row,
                  output run_last, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input out_col, input out_row,
                  input run_last, input frame_last, output ready);
endinterface
`default_nettype wire

/* src/gray_pyramid_reduce_5x5_unit.sv */
`default_nettype none
// Path: a pixel word passes the B pixel register, the C pending-result mask and then the result register.
// Throughput: one pixel word per cycle while results drain; a pixel that completes more than one result
//   holds the input while the single result register drains one word a cycle with out_res.ready high.
// Reset (rst_n low, synchronous): counters, pipeline valids and column-sum windows clear,
//   size registers return to 640 x 480, truncating mode. Line buffers are not cleared: row 0 of each
//   frame writes every column of the even and partial-sum buffers, row 1 of the odd buffer, before use.
module gray_pyramid_reduce_5x5_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  gpr_pix_if.sink                          in_pix,
  gpr_res_if.source                        out_res,
  input  wire                              cfg_we,
  input  wire [gpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [gpr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gpr_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration and effective frame size
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] img_w_r, img_h_r;
  logic                  round_r;
  logic [WIDTH_W-1:0]    eff_w;
  logic [HEIGHT_W-1:0]   eff_h;
  logic [COL_W-1:0]      last_col;
  logic [ROW_W-1:0]      last_row;
  logic                  size_wr;

  // zero acts as one, oversize clamps to the buffer depth (width) or to HEIGHT_LIMIT (height)
  always_comb begin
    if (img_w_r == '0) begin
      eff_w = WIDTH_W'(1);
    end else if (int'(img_w_r) > MAX_WIDTH) begin
      eff_w = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_w = WIDTH_W'(img_w_r);
    end
    if (img_h_r == '0) begin
      eff_h = HEIGHT_W'(1);
    end else if (int'(img_h_r) > HEIGHT_LIMIT) begin
      eff_h = HEIGHT_W'(HEIGHT_LIMIT);
    end else begin
      eff_h = HEIGHT_W'(img_h_r);
    end
  end

  assign last_col = COL_W'(eff_w - 1'b1);
  assign last_row = ROW_W'(eff_h - 1'b1);
  assign size_wr  = cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

  // ---------------------------------------------------------------------------
  // Handshake and stage control
  //   B: pixel register plus registered line-buffer reads (vertical pass)
  //   C: result sequencer over the pending-result mask (horizontal pass)
  //   O: result register
  // ---------------------------------------------------------------------------
  logic in_acc, b_adv, c_send, c_done, c_free, o_free, sel_last;
  logic b_vld_r, o_vld_r;
  logic [3:0] c_mask_r, c_mask_new, c_rest;

  assign o_free       = !o_vld_r || out_res.ready;
  assign c_send       = (c_mask_r != '0) && o_free;
  assign c_done       = c_send && sel_last;
  assign c_free       = (c_mask_r == '0) || c_done;
  assign b_adv        = b_vld_r && c_free;
  assign in_pix.ready = !b_vld_r || b_adv;
  assign in_acc       = in_pix.valid && in_pix.ready;

  // ---------------------------------------------------------------------------
  // Raster position
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] col_cnt_r;
  logic [ROW_W-1:0] row_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r   <= RST_IMAGE_WIDTH;
      img_h_r   <= RST_IMAGE_HEIGHT;
      round_r   <= 1'b0;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH:  img_w_r <= cfg_data;
          CFG_IMAGE_HEIGHT: img_h_r <= cfg_data;
          CFG_ROUND_MODE:   round_r <= cfg_data[0];
          default: ;
        endcase
      end
      // size write restarts the frame
      if (size_wr) begin
        col_cnt_r <= '0;
        row_cnt_r <= '0;
      end else if (in_acc) begin
        if (col_cnt_r == last_col) begin
          col_cnt_r <= '0;
          row_cnt_r <= (row_cnt_r == last_row) ? '0 : row_cnt_r + 1'b1;
        end else begin
          col_cnt_r <= col_cnt_r + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B registers
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]     b_pix_r;
  logic [COL_W-1:0]     b_col_r;
  logic [OUT_IDX_W-1:0] b_rhalf_r;
  logic                 b_reven_r, b_rge2_r, b_rlast_r, b_clast_r, b_cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (in_pix.ready) begin
      b_vld_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_pix_r   <= in_pix.pixel_in;
      b_col_r   <= col_cnt_r;
      b_rhalf_r <= OUT_IDX_W'(row_cnt_r >> 1);
      b_reven_r <= !row_cnt_r[0];
      b_rge2_r  <= (row_cnt_r >= ROW_W'(2));
      b_rlast_r <= (row_cnt_r == last_row);
      b_clast_r <= (col_cnt_r == last_col);
      b_cz_r    <= (col_cnt_r == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffers: written as a pixel leaves B, read as a pixel enters B.
  // Same column on both ports only for a one-pixel-wide image: write data forwarded.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]   even_mem [MAX_WIDTH];
  logic [PIX_W-1:0]   odd_mem  [MAX_WIDTH];
  logic [UPSUM_W-1:0] up_mem   [MAX_WIDTH];
  logic [PIX_W-1:0]   ev_rd_r, od_rd_r;
  logic [UPSUM_W-1:0] up_rd_r, up_new;
  logic               ev_we, od_we, same_col, byp_hit;

  assign ev_we    = b_adv && b_reven_r;
  assign od_we    = b_adv && !b_reven_r;
  assign same_col = (b_col_r == col_cnt_r);
  assign byp_hit  = in_acc && b_adv && same_col;

  always_ff @(posedge clk) begin
    if (ev_we) begin
      even_mem[b_col_r] <= b_pix_r;
      up_mem[b_col_r]   <= up_new;
    end
    if (od_we) begin
      odd_mem[b_col_r] <= b_pix_r;
    end
    if (in_acc) begin
      ev_rd_r <= (ev_we && same_col) ? b_pix_r : even_mem[col_cnt_r];
      up_rd_r <= (ev_we && same_col) ? up_new  : up_mem[col_cnt_r];
      od_rd_r <= (od_we && same_col) ? b_pix_r : odd_mem[col_cnt_r];
    end
  end

  // ---------------------------------------------------------------------------
  // Vertical pass: up to two column sums, one per output row centre
  // ---------------------------------------------------------------------------
  logic [VSUM_W-1:0]    vs_mid, vs_bot, vs_odd, vs0, vs1;
  logic [OUT_IDX_W-1:0] vrow0, vrow1;
  logic                 use0, use1, kind_even, kind_edge;

  always_comb begin
    up_new = b_rge2_r ? (UPSUM_W'(ev_rd_r) + UPSUM_W'(od_rd_r) * UPSUM_W'(TAP_4))
                      : (UPSUM_W'(b_pix_r) * UPSUM_W'(TAP_5));
    // full five-row sum centred two rows up
    vs_mid = VSUM_W'(up_rd_r) + VSUM_W'(ev_rd_r) * VSUM_W'(TAP_6)
           + VSUM_W'(od_rd_r) * VSUM_W'(TAP_4) + VSUM_W'(b_pix_r);
    // bottom edge, centre on this even row
    vs_bot = VSUM_W'(up_new) + VSUM_W'(b_pix_r) * VSUM_W'(TAP_11);
    // bottom edge, centre on the even row above this odd row
    vs_odd = VSUM_W'(up_rd_r) + VSUM_W'(ev_rd_r) * VSUM_W'(TAP_6)
           + VSUM_W'(b_pix_r) * VSUM_W'(TAP_5);

    vs0   = vs_odd;
    vs1   = vs_bot;
    vrow0 = b_rhalf_r;
    vrow1 = b_rhalf_r;
    use0  = b_rlast_r;
    use1  = 1'b0;
    if (b_reven_r) begin
      if (b_rge2_r) begin
        vs0   = vs_mid;
        vrow0 = b_rhalf_r - 1'b1;
        use0  = 1'b1;
        use1  = b_rlast_r;
      end else begin
        vs0 = vs_bot;
      end
    end

    kind_even  = !b_col_r[0] && !b_cz_r;
    kind_edge  = b_clast_r;
    c_mask_new = {use1 && kind_edge, use1 && kind_even, use0 && kind_edge, use0 && kind_even};
  end

  // ---------------------------------------------------------------------------
  // Column-sum windows, updated as a pixel moves into C
  // ---------------------------------------------------------------------------
  logic [VSUM_W-1:0] win_r [2][WIN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < WIN; i++) begin
          win_r[s][i] <= '0;
        end
      end
    end else if (b_adv) begin
      if (use0) begin
        for (int i = 0; i < WIN - 1; i++) begin
          win_r[0][i] <= b_cz_r ? vs0 : win_r[0][i+1];
        end
        win_r[0][WIN-1] <= vs0;
      end
      if (use1) begin
        for (int i = 0; i < WIN - 1; i++) begin
          win_r[1][i] <= b_cz_r ? vs1 : win_r[1][i+1];
        end
        win_r[1][WIN-1] <= vs1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: one result per cycle while the result register is free, lowest pending bit first (row-major order)
  // ---------------------------------------------------------------------------
  logic [OUT_IDX_W-1:0] c_row_r [2];
  logic [OUT_IDX_W-1:0] c_chalf_r;
  logic                 c_codd_r, c_frame_r;
  logic                 sel_s, sel_k;
  logic [3:0]           sel_bit;
  logic [HSUM_W-1:0]    wv [WIN];
  logic [HSUM_W-1:0]    hsum, hsum_rnd;
  logic [PIX_W-1:0]     pix_res;
  logic [OUT_IDX_W-1:0] col_res;

  always_comb begin
    priority if (c_mask_r[0]) begin
      sel_s = 1'b0; sel_k = 1'b0; sel_bit = 4'b0001;
    end else if (c_mask_r[1]) begin
      sel_s = 1'b0; sel_k = 1'b1; sel_bit = 4'b0010;
    end else if (c_mask_r[2]) begin
      sel_s = 1'b1; sel_k = 1'b0; sel_bit = 4'b0100;
    end else begin
      sel_s = 1'b1; sel_k = 1'b1; sel_bit = 4'b1000;
    end
    c_rest   = c_mask_r & ~sel_bit;
    sel_last = (c_rest == '0);

    for (int i = 0; i < WIN; i++) begin
      wv[i] = HSUM_W'(win_r[sel_s][i]);
    end
    if (!sel_k) begin
      hsum = wv[0] + wv[1] * HSUM_W'(TAP_4) + wv[2] * HSUM_W'(TAP_6)
           + wv[3] * HSUM_W'(TAP_4) + wv[4];
    end else if (c_codd_r) begin
      // right edge, centre one column left of the last
      hsum = wv[1] + wv[2] * HSUM_W'(TAP_4) + wv[3] * HSUM_W'(TAP_6)
           + wv[4] * HSUM_W'(TAP_5);
    end else begin
      // right edge, centre on the last column
      hsum = wv[2] + wv[3] * HSUM_W'(TAP_4) + wv[4] * HSUM_W'(TAP_11);
    end
    hsum_rnd = hsum + (round_r ? HSUM_W'(ROUND_BIAS) : '0);
    pix_res  = hsum_rnd[NORM_SHIFT+PIX_W-1:NORM_SHIFT];
    col_res  = sel_k ? c_chalf_r : (c_chalf_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_mask_r <= '0;
    end else if (b_adv) begin
      c_mask_r <= c_mask_new;
    end else if (c_send) begin
      c_mask_r <= c_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      c_row_r[0] <= vrow0;
      c_row_r[1] <= vrow1;
      c_chalf_r  <= OUT_IDX_W'(b_col_r >> 1);
      c_codd_r   <= b_col_r[0];
      c_frame_r  <= b_rlast_r && b_clast_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]     o_pix_r;
  logic [OUT_IDX_W-1:0] o_col_r, o_row_r;
  logic                 o_run_last_r, o_frame_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (c_send) begin
      o_vld_r <= 1'b1;
    end else if (out_res.ready) begin
      o_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_send) begin
      o_pix_r        <= pix_res;
      o_col_r        <= col_res;
      o_row_r        <= c_row_r[sel_s];
      o_run_last_r   <= sel_last;
      o_frame_last_r <= sel_last && c_frame_r;
    end
  end

  assign out_res.valid      = o_vld_r;
  assign out_res.pixel_out  = o_pix_r;
  assign out_res.out_col    = o_col_r;
  assign out_res.out_row    = o_row_r;
  assign out_res.run_last   = o_run_last_r;
  assign out_res.frame_last = o_frame_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    col_cnt_r <= last_col && row_cnt_r <= last_row)
    else $error("raster position outside frame");

  a_fwd_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    byp_hit |-> (last_col == '0))
    else $error("line buffer forwarding on a multi-column image");

  a_seq_blocks_b: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(c_mask_r) > 1) |-> !b_adv)
    else $error("pixel moved into C while results pending");

  a_seq_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (c_send && !sel_last) |=> (c_mask_r != '0))
    else $error("result run cut short");

  a_frame_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && o_frame_last_r) |-> o_run_last_r)
    else $error("frame end not on last word of run");

endmodule
`default_nettype wire
